@@ rtl/sscl_pkg.sv @@
// Shared types, register codes and reset values for the stationary sleep controller.
`timescale 1ns / 1ps
`default_nettype none

package sscl_pkg;

	// Stay-awake cause reported with every result
	typedef enum logic [3:0] {
		ST_BOOT      = 4'd0,
		ST_SLEEPING  = 4'd1,
		ST_NO_SENSOR = 4'd2,
		ST_GRACE     = 4'd3,
		ST_ACTIVE    = 4'd4,
		ST_DRIFT     = 4'd5,
		ST_NOGPS     = 4'd6,
		ST_WINDOW    = 4'd7,
		ST_LINK      = 4'd8,
		ST_SETTLE    = 4'd9
	} stay_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_BOOT_TIME     = 3'd0,
		REG_BOOT_GRACE    = 3'd1,
		REG_FIX_STALE     = 3'd2,
		REG_WINDOW        = 3'd3,
		REG_MIN_FIXES     = 3'd4,
		REG_DRIFT_LIMIT   = 3'd5,
		REG_NOGPS_GRACE   = 3'd6,
		REG_RECOVERY_HOLD = 3'd7
	} reg_idx_t;

	localparam logic [31:0] RST_BOOT_TIME     = 32'd0;
	localparam logic [31:0] RST_BOOT_GRACE    = 32'd60000;
	localparam logic [31:0] RST_FIX_STALE     = 32'd30000;
	localparam logic [31:0] RST_WINDOW        = 32'd300000;
	localparam logic [7:0]  RST_MIN_FIXES     = 8'd5;
	localparam logic [15:0] RST_DRIFT_LIMIT   = 16'd2000;
	localparam logic [31:0] RST_NOGPS_GRACE   = 32'd300000;
	localparam logic [31:0] RST_RECOVERY_HOLD = 32'd600000;

	typedef struct packed {
		logic [31:0] boot_time;
		logic [31:0] boot_grace_ms;
		logic [31:0] fix_stale_ms;
		logic [31:0] window_ms;
		logic [7:0]  min_fixes;
		logic [15:0] drift_limit_cm;
		logic [31:0] nogps_grace_ms;
		logic [31:0] recovery_hold_ms;
	} cfg_t;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        sensor_present;
		logic        motion_busy;
		logic [31:0] fix_time_ms;
		logic [15:0] window_drift_cm;
		logic [7:0]  window_fixes;
		logic [31:0] still_for_ms;
		logic        link_ready;
		logic [31:0] link_ok_time_ms;
		logic        settle_ok;
	} tick_t;

	typedef struct packed {
		logic        sleep_now;
		logic        sleep_by_gps;
		stay_t       stay_code;
		logic        window_open;
		logic [31:0] window_held_ms;
		logic        gps_trusted;
		logic [15:0] resets_moving;
		logic [15:0] resets_by_drift;
		logic [15:0] resets_no_gps;
		logic [7:0]  seen_fixes;
		logic [15:0] seen_drift_cm;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/stationary_sleep_controller_top.sv @@
// Top level of the stationary sleep controller: tick register, evaluation, result register.
// A tick taken into the tick register passes to the result register once that is free (out_valid high).
// Throughput: one tick per cycle unless out_stall holds a full result register; the gates are one
// pass of compares between the tick register and the result register, and the controller state updates in that pass.
// Reset (arst_n low, asynchronous): both stages empty, counters and window cleared,
// stay code boot, configuration registers back to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module stationary_sleep_controller_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// Tick channel
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] now_ms,
	input  wire logic        sensor_present,
	input  wire logic        motion_busy,
	input  wire logic [31:0] fix_time_ms,
	input  wire logic [15:0] window_drift_cm,
	input  wire logic [7:0]  window_fixes,
	input  wire logic [31:0] still_for_ms,
	input  wire logic        link_ready,
	input  wire logic [31:0] link_ok_time_ms,
	input  wire logic        settle_ok,
	// Result channel
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             sleep_now,
	output logic             sleep_by_gps,
	output logic [3:0]       stay_code,
	output logic             window_open,
	output logic [31:0]      window_held_ms,
	output logic             gps_trusted,
	output logic [15:0]      resets_moving,
	output logic [15:0]      resets_by_drift,
	output logic [15:0]      resets_no_gps,
	output logic [7:0]       seen_fixes,
	output logic [15:0]      seen_drift_cm
);

	sscl_pkg::cfg_t    cfg;
	sscl_pkg::tick_t   tick_s1;
	logic              valid_s1;
	sscl_pkg::result_t res_comb;
	sscl_pkg::result_t res_s2;
	logic              valid_s2;
	logic              s2_free;
	logic              advance;
	logic              in_xfer;

	assign cfg_ready = 1'b1;

	sscl_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Handshake: stage 1 moves on whenever the result register is free
	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_xfer  = in_valid && !in_stall;

	// Tick register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			tick_s1.now_ms          <= now_ms;
			tick_s1.sensor_present  <= sensor_present;
			tick_s1.motion_busy     <= motion_busy;
			tick_s1.fix_time_ms     <= fix_time_ms;
			tick_s1.window_drift_cm <= window_drift_cm;
			tick_s1.window_fixes    <= window_fixes;
			tick_s1.still_for_ms    <= still_for_ms;
			tick_s1.link_ready      <= link_ready;
			tick_s1.link_ok_time_ms <= link_ok_time_ms;
			tick_s1.settle_ok       <= settle_ok;
		end
	end

	sscl_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.tick    (tick_s1),
		.advance (advance),
		.res     (res_comb)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid       = valid_s2;
	assign sleep_now       = res_s2.sleep_now;
	assign sleep_by_gps    = res_s2.sleep_by_gps;
	assign stay_code       = res_s2.stay_code;
	assign window_open     = res_s2.window_open;
	assign window_held_ms  = res_s2.window_held_ms;
	assign gps_trusted     = res_s2.gps_trusted;
	assign resets_moving   = res_s2.resets_moving;
	assign resets_by_drift = res_s2.resets_by_drift;
	assign resets_no_gps   = res_s2.resets_no_gps;
	assign seen_fixes      = res_s2.seen_fixes;
	assign seen_drift_cm   = res_s2.seen_drift_cm;

`ifndef SYNTHESIS
	// A committing tick keeps its window open
	a_commit_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sleep_now |-> window_open)
		else $error("sleep committed without an open window");

	// The sleep reason only accompanies a commit
	a_reason_commit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sleep_now |-> !sleep_by_gps)
		else $error("sleep reason set without a commit");

	// No window means no held time
	a_held_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !window_open |-> window_held_ms == 32'd0)
		else $error("held time reported with no window");

	// A full pipeline under a stalled result stops the tick channel
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_stall |-> in_stall)
		else $error("tick taken while both stages are held");
`endif

endmodule

`default_nettype wire

@@ rtl/sscl_cfg.sv @@
// Configuration register file of the stationary sleep controller.
`timescale 1ns / 1ps
`default_nettype none

module sscl_cfg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [2:0]       wr_index,
	input  wire logic [31:0]      wr_data,
	output sscl_pkg::cfg_t        cfg
);

	sscl_pkg::cfg_t cfg_q;

	// Write one register per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.boot_time        <= sscl_pkg::RST_BOOT_TIME;
			cfg_q.boot_grace_ms    <= sscl_pkg::RST_BOOT_GRACE;
			cfg_q.fix_stale_ms     <= sscl_pkg::RST_FIX_STALE;
			cfg_q.window_ms        <= sscl_pkg::RST_WINDOW;
			cfg_q.min_fixes        <= sscl_pkg::RST_MIN_FIXES;
			cfg_q.drift_limit_cm   <= sscl_pkg::RST_DRIFT_LIMIT;
			cfg_q.nogps_grace_ms   <= sscl_pkg::RST_NOGPS_GRACE;
			cfg_q.recovery_hold_ms <= sscl_pkg::RST_RECOVERY_HOLD;
		end else if (wr_en) begin
			unique case (sscl_pkg::reg_idx_t'(wr_index))
				sscl_pkg::REG_BOOT_TIME:     cfg_q.boot_time        <= wr_data;
				sscl_pkg::REG_BOOT_GRACE:    cfg_q.boot_grace_ms    <= wr_data;
				sscl_pkg::REG_FIX_STALE:     cfg_q.fix_stale_ms     <= wr_data;
				sscl_pkg::REG_WINDOW:        cfg_q.window_ms        <= wr_data;
				sscl_pkg::REG_MIN_FIXES:     cfg_q.min_fixes        <= wr_data[7:0];
				sscl_pkg::REG_DRIFT_LIMIT:   cfg_q.drift_limit_cm   <= wr_data[15:0];
				sscl_pkg::REG_NOGPS_GRACE:   cfg_q.nogps_grace_ms   <= wr_data;
				sscl_pkg::REG_RECOVERY_HOLD: cfg_q.recovery_hold_ms <= wr_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/sscl_core.sv @@
// Gate evaluation and controller state for one tick per cycle while advance is high.
`timescale 1ns / 1ps
`default_nettype none

module sscl_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sscl_pkg::cfg_t   cfg,
	input  wire sscl_pkg::tick_t  tick,
	input  wire logic             advance,
	output sscl_pkg::result_t     res
);

	// Controller state
	logic [31:0]     win_start_q;
	logic            win_valid_q;
	logic            asleep_q;
	sscl_pkg::stay_t stay_q;
	logic [15:0]     cnt_moving_q;
	logic [15:0]     cnt_drift_q;
	logic [15:0]     cnt_nogps_q;
	logic [15:0]     held_drift_q;
	logic [7:0]      held_fixes_q;
	logic            held_trusted_q;

	// Next state
	logic [31:0]     win_start_d;
	logic            win_valid_d;
	logic            asleep_d;
	sscl_pkg::stay_t stay_d;
	logic [15:0]     cnt_moving_d;
	logic [15:0]     cnt_drift_d;
	logic [15:0]     cnt_nogps_d;
	logic [15:0]     held_drift_d;
	logic [7:0]      held_fixes_d;
	logic            held_trusted_d;
	logic            sleep_now;
	logic            by_gps;

	// Elapsed times and gate tests
	logic [31:0] since_boot;
	logic [31:0] fix_age;
	logic [31:0] win_age;
	logic [31:0] link_age;
	logic [31:0] since_link;
	logic        in_grace;
	logic        fix_avail;
	logic [15:0] drift_eff;
	logic [7:0]  fixes_eff;
	logic        confident;
	logic        drift_fail;
	logic        still_fail;
	logic        win_elapsed;
	logic        link_hold;

	assign since_boot  = tick.now_ms - cfg.boot_time;
	assign fix_age     = tick.now_ms - tick.fix_time_ms;
	assign win_age     = tick.now_ms - win_start_q;
	assign link_age    = tick.now_ms - tick.link_ok_time_ms;
	assign since_link  = (tick.link_ok_time_ms != 32'd0) ? link_age : since_boot;
	assign in_grace    = since_boot < cfg.boot_grace_ms;
	assign fix_avail   = (tick.fix_time_ms != 32'd0) && (fix_age < cfg.fix_stale_ms);
	assign drift_eff   = fix_avail ? tick.window_drift_cm : 16'd0;
	assign fixes_eff   = fix_avail ? tick.window_fixes : 8'd0;
	assign confident   = fix_avail && (fixes_eff >= cfg.min_fixes);
	assign drift_fail  = confident && (drift_eff > cfg.drift_limit_cm);
	assign still_fail  = !confident && (tick.still_for_ms < cfg.nogps_grace_ms);
	assign win_elapsed = win_age >= cfg.window_ms;
	assign link_hold   = !tick.link_ready && (since_link < cfg.recovery_hold_ms);

	// Walk the gates in order; a failed motion, drift, no-GPS or settle gate drops the window
	always_comb begin
		win_start_d    = win_start_q;
		win_valid_d    = win_valid_q;
		asleep_d       = asleep_q;
		stay_d         = stay_q;
		cnt_moving_d   = cnt_moving_q;
		cnt_drift_d    = cnt_drift_q;
		cnt_nogps_d    = cnt_nogps_q;
		held_drift_d   = held_drift_q;
		held_fixes_d   = held_fixes_q;
		held_trusted_d = held_trusted_q;
		sleep_now      = 1'b0;
		by_gps         = 1'b0;
		priority if (asleep_q || !tick.sensor_present) begin
			stay_d = tick.sensor_present ? sscl_pkg::ST_SLEEPING : sscl_pkg::ST_NO_SENSOR;
		end else if (in_grace) begin
			stay_d = sscl_pkg::ST_GRACE;
		end else if (tick.motion_busy) begin
			cnt_moving_d = cnt_moving_q + 16'(win_valid_q);
			win_valid_d  = 1'b0;
			win_start_d  = '0;
			stay_d       = sscl_pkg::ST_ACTIVE;
		end else begin
			held_drift_d   = drift_eff;
			held_fixes_d   = fixes_eff;
			held_trusted_d = confident;
			priority if (drift_fail) begin
				cnt_drift_d = cnt_drift_q + 16'(win_valid_q);
				win_valid_d = 1'b0;
				win_start_d = '0;
				stay_d      = sscl_pkg::ST_DRIFT;
			end else if (still_fail) begin
				cnt_nogps_d = cnt_nogps_q + 16'(win_valid_q);
				win_valid_d = 1'b0;
				win_start_d = '0;
				stay_d      = sscl_pkg::ST_NOGPS;
			end else if (!win_valid_q) begin
				win_valid_d = 1'b1;
				win_start_d = tick.now_ms;
				stay_d      = sscl_pkg::ST_WINDOW;
			end else if (!win_elapsed) begin
				stay_d = sscl_pkg::ST_WINDOW;
			end else if (link_hold) begin
				stay_d = sscl_pkg::ST_LINK;
			end else if (tick.settle_ok) begin
				asleep_d  = 1'b1;
				sleep_now = 1'b1;
				by_gps    = confident;
			end else begin
				cnt_moving_d = cnt_moving_q + 16'd1;
				win_valid_d  = 1'b0;
				win_start_d  = '0;
				stay_d       = sscl_pkg::ST_SETTLE;
			end
		end
	end

	// Report the state as it stands after this tick
	always_comb begin
		res.sleep_now       = sleep_now;
		res.sleep_by_gps    = by_gps;
		res.stay_code       = stay_d;
		res.window_open     = win_valid_d;
		res.window_held_ms  = win_valid_d ? (tick.now_ms - win_start_d) : 32'd0;
		res.gps_trusted     = held_trusted_d;
		res.resets_moving   = cnt_moving_d;
		res.resets_by_drift = cnt_drift_d;
		res.resets_no_gps   = cnt_nogps_d;
		res.seen_fixes      = held_fixes_d;
		res.seen_drift_cm   = held_drift_d;
	end

	// Commit state when the tick moves on to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_start_q    <= '0;
			win_valid_q    <= 1'b0;
			asleep_q       <= 1'b0;
			stay_q         <= sscl_pkg::ST_BOOT;
			cnt_moving_q   <= '0;
			cnt_drift_q    <= '0;
			cnt_nogps_q    <= '0;
			held_drift_q   <= '0;
			held_fixes_q   <= '0;
			held_trusted_q <= 1'b0;
		end else if (advance) begin
			win_start_q    <= win_start_d;
			win_valid_q    <= win_valid_d;
			asleep_q       <= asleep_d;
			stay_q         <= stay_d;
			cnt_moving_q   <= cnt_moving_d;
			cnt_drift_q    <= cnt_drift_d;
			cnt_nogps_q    <= cnt_nogps_d;
			held_drift_q   <= held_drift_d;
			held_fixes_q   <= held_fixes_d;
			held_trusted_q <= held_trusted_d;
		end
	end

endmodule

`default_nettype wire
